FILE: design/ust_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ust_pkg: shared types and constants for the unordered set table
// Request kinds, error codes, sequencer states and the result bundle.
// ----------------------------------------------------------------------------
package ust_pkg;

   // Table size default, handed down from the top level
   localparam int TableDepthDefault = 16;

   // Widths fixed by the request and result fields
   localparam int KindWidth  = 2;
   localparam int ElemWidth  = 32;
   localparam int CountWidth = 5;

   // Request kinds
   localparam logic [KindWidth-1:0] REQ_INSERT = 2'd0;
   localparam logic [KindWidth-1:0] REQ_DELETE = 2'd1;
   localparam logic [KindWidth-1:0] REQ_QUERY  = 2'd2;

   // Error codes
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_DUPLICATE = 2'd1,
      ERR_FULL      = 2'd2,
      ERR_ABSENT    = 2'd3
   } err_code_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESOLVE,
      ST_SHIFT,
      ST_DONE
   } seq_state_type;

   // Finished result handed from the sequencer to the output register
   typedef struct packed {
      logic                  valid;
      logic                  success;
      err_code_type          error_code;
      logic [CountWidth-1:0] member_count;
   } result_type;

endpackage
`default_nettype wire

FILE: design/unordered_set_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unordered_set_table: bounded set of distinct 32-bit elements
// Insert, delete and membership query over a table kept in insertion order.
// ----------------------------------------------------------------------------
// Sequence: accept the item and read slot 0, compare the stored entries in
//   order until a match or the last entry, resolve; a matching delete then
//   moves the later entries down; the result is held until the output is free.
// Issue: one item at a time; the next item is taken in the cycle after
//   the result moves to the output register, one read port, one comparator.
// Reset: synchronous; count and sequencer clear, element memory does not.
// ----------------------------------------------------------------------------
module unordered_set_table
   import ust_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [KindWidth-1:0]  req_type,
   input  wire logic signed [ElemWidth-1:0] req_element,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_success,
   output logic [1:0]                 rsp_error_code,
   output logic [CountWidth-1:0]      rsp_member_count
);

   localparam int AddrWidth = $clog2(TABLE_DEPTH);
   localparam int CntWidth  = $clog2(TABLE_DEPTH + 1);

   logic                 busy;
   logic                 wr_en;
   logic [AddrWidth-1:0] wr_addr;
   logic [ElemWidth-1:0] wr_data;
   logic                 rd_en;
   logic [AddrWidth-1:0] rd_addr;
   logic [ElemWidth-1:0] rd_data;
   logic                 out_free;
   result_type           result;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  success_ff, success_in;
   err_code_type          err_ff, err_in;
   logic [CountWidth-1:0] count_ff, count_in;

   ust_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AddrWidth   (AddrWidth),
      .CntWidth    (CntWidth)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_type),
      .req_value (req_element),
      .busy      (busy),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .out_free  (out_free),
      .result    (result)
   );

   ust_store #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AddrWidth   (AddrWidth)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = busy;

   // Output register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      success_in   = success_ff;
      err_in       = err_ff;
      count_in     = count_ff;
      if (out_free) begin
         rsp_valid_in = result.valid;
         if (result.valid) begin
            success_in = result.success;
            err_in     = result.error_code;
            count_in   = result.member_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      success_ff <= success_in;
      err_ff     <= err_in;
      count_ff   <= count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_success      = success_ff;
   assign rsp_error_code   = err_ff;
   assign rsp_member_count = count_ff;

   // A successful item never carries an error code
   a_success_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_success |-> rsp_error_code == ERR_NONE)
      else $error("successful item carries an error code");

   // The sequencer is busy in the cycle after it takes an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request port open right after accepting an item");

   // A stalled result stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

endmodule
`default_nettype wire

FILE: design/ust_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ust_store: element memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ust_store
   import ust_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int AddrWidth   = $clog2(TABLE_DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AddrWidth-1:0] wr_addr,
   input  wire logic [ElemWidth-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [AddrWidth-1:0] rd_addr,
   output logic      [ElemWidth-1:0] rd_data
);

   logic [ElemWidth-1:0] mem_ff [TABLE_DEPTH];
   logic [ElemWidth-1:0] rdata_ff;

   // Storage array, no reset: entries at or above the count are never compared or moved
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule
`default_nettype wire

FILE: design/ust_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ust_ctrl: request sequencer with the shared compare unit
// Scans the table one entry a cycle, resolves the request, then shifts
// later entries down on a delete that matches. Holds the element count.
// ----------------------------------------------------------------------------
module ust_ctrl
   import ust_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int AddrWidth   = $clog2(TABLE_DEPTH),
   parameter int CntWidth    = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request side
   input  wire logic                 req_valid,
   input  wire logic [KindWidth-1:0] req_kind,
   input  wire logic [ElemWidth-1:0] req_value,
   output logic                      busy,
   // memory side
   output logic                      wr_en,
   output logic      [AddrWidth-1:0] wr_addr,
   output logic      [ElemWidth-1:0] wr_data,
   output logic                      rd_en,
   output logic      [AddrWidth-1:0] rd_addr,
   input  wire logic [ElemWidth-1:0] rd_data,
   // result side
   input  wire logic                 out_free,
   output result_type                result
);

   seq_state_type        state_ff, state_in;
   logic [KindWidth-1:0] kind_ff, kind_in;
   logic [ElemWidth-1:0] value_ff, value_in;
   logic [CntWidth-1:0]  pos_ff, pos_in;
   logic [CntWidth-1:0]  count_ff, count_in;
   logic                 found_ff, found_in;
   logic                 success_ff, success_in;
   err_code_type         err_ff, err_in;

   logic [CntWidth-1:0]  pos_plus1;
   logic [CntWidth:0]    pos_plus2;
   logic [31:0]          count_wide;

   assign pos_plus1  = pos_ff + CntWidth'(1);
   assign pos_plus2  = {1'b0, pos_ff} + (CntWidth + 1)'(2);
   assign count_wide = 32'(count_ff);

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Per-item working registers
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      value_ff   <= value_in;
      pos_ff     <= pos_in;
      found_ff   <= found_in;
      success_ff <= success_in;
      err_ff     <= err_in;
   end

   // Next state, memory control and results
   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      value_in   = value_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      found_in   = found_ff;
      success_in = success_ff;
      err_in     = err_ff;
      wr_en      = 1'b0;
      wr_addr    = pos_ff[AddrWidth-1:0];
      wr_data    = rd_data;
      rd_en      = 1'b0;
      rd_addr    = '0;
      busy       = (state_ff != ST_IDLE);
      result.valid        = 1'b0;
      result.success      = success_ff;
      result.error_code   = err_ff;
      result.member_count = count_wide[CountWidth-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in    = req_kind;
               value_in   = req_value;
               pos_in     = '0;
               found_in   = 1'b0;
               success_in = 1'b0;
               err_in     = ERR_NONE;
               // fetch the first entry while latching the item
               rd_en      = 1'b1;
               rd_addr    = '0;
               state_in   = (count_ff == '0) ? ST_RESOLVE : ST_SCAN;
            end
         end

         ST_SCAN: begin
            // rd_data holds the entry at pos_ff
            if (rd_data == value_ff) begin
               found_in = 1'b1;
               state_in = ST_RESOLVE;
            end else if (pos_plus1 == count_ff) begin
               state_in = ST_RESOLVE;
            end else begin
               pos_in  = pos_plus1;
               rd_en   = 1'b1;
               rd_addr = pos_plus1[AddrWidth-1:0];
            end
         end

         ST_RESOLVE: begin
            state_in = ST_DONE;
            case (kind_ff)
               REQ_INSERT: begin
                  if (found_ff) begin
                     err_in = ERR_DUPLICATE;
                  end else if (count_ff == CntWidth'(TABLE_DEPTH)) begin
                     err_in = ERR_FULL;
                  end else begin
                     wr_en      = 1'b1;
                     wr_addr    = count_ff[AddrWidth-1:0];
                     wr_data    = value_ff;
                     count_in   = count_ff + CntWidth'(1);
                     success_in = 1'b1;
                  end
               end
               REQ_DELETE: begin
                  if (!found_ff) begin
                     err_in = ERR_ABSENT;
                  end else begin
                     success_in = 1'b1;
                     if (pos_plus1 < count_ff) begin
                        // later entries to move down
                        rd_en    = 1'b1;
                        rd_addr  = pos_plus1[AddrWidth-1:0];
                        state_in = ST_SHIFT;
                     end else begin
                        count_in = count_ff - CntWidth'(1);
                     end
                  end
               end
               REQ_QUERY: begin
                  if (found_ff) begin
                     success_in = 1'b1;
                  end else begin
                     err_in = ERR_ABSENT;
                  end
               end
               default: begin
                  // unused kind: no operation
               end
            endcase
         end

         ST_SHIFT: begin
            // rd_data holds the entry at pos_ff + 1
            wr_en   = 1'b1;
            wr_addr = pos_ff[AddrWidth-1:0];
            wr_data = rd_data;
            if (pos_plus2 < {1'b0, count_ff}) begin
               rd_en   = 1'b1;
               rd_addr = pos_plus2[AddrWidth-1:0];
               pos_in  = pos_plus1;
            end else begin
               count_in = count_ff - CntWidth'(1);
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            result.valid = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire
